/* rtl/ps2_mouse_packet_assembler_fifo_top_defines.svh */
// Assertion macros shared by the packet assembler RTL.
`ifndef PS2_MOUSE_PACKET_ASSEMBLER_FIFO_TOP_DEFINES_SVH
`define PS2_MOUSE_PACKET_ASSEMBLER_FIFO_TOP_DEFINES_SVH

// Check an implication on every clock edge outside reset.
`define PS2MPA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check an implication on every clock edge, reset included.
`define PS2MPA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ps2mpa_pkg.sv */
// Types and constants of the PS/2 mouse packet assembler.
package ps2mpa_pkg;

   localparam int BYTE_W      = 8;
   localparam int BUTTONS_W   = 3;
   localparam int SYNC_BIT    = 3;
   localparam int ENTRY_W     = BUTTONS_W + 2 * BYTE_W;
   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = 1;

   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;

   typedef struct packed {
      logic signed [BYTE_W-1:0]    delta_y;
      logic signed [BYTE_W-1:0]    delta_x;
      logic        [BUTTONS_W-1:0] buttons;
   } entry_type;

endpackage

/* rtl/ps2_mouse_packet_assembler_fifo_top.sv */
// Top level of the PS/2 mouse packet assembler with its packet queue.
//
// Usage:
//   req channel: each word is either a controller byte (tuser[0] = 0) with
//   its auxiliary-port flag in tuser[1] and the byte in tdata, or a read
//   request (tuser[0] = 1). Auxiliary bytes build three-byte mouse packets;
//   a first byte with bit 3 clear is dropped to regain sync. A finished
//   packet goes into a ring queue of QUEUE_DEPTH entries (QUEUE_DEPTH-1
//   usable) and is dropped when the queue is full.
//   rsp channel: one word per read request, tuser = read_ok, tdata holds
//   buttons, delta_x and delta_y, all zero when the queue was empty.
//   Read path: the queue memory is read at the edge that accepts a read
//   request, and the output register loads at the next edge unless rsp
//   stalls. One word is accepted each cycle while rsp drains.
//   Stall: when rsp_tready is low the output register and the memory read
//   stage hold one result each; after that req_tready drops until rsp
//   drains. Bytes and reads are treated alike by this interlock.
//   Reset: synchronous; clears packet position, pointers and valid flags.
//   Queue memory contents are not cleared and need no clearing pass.
`include "ps2_mouse_packet_assembler_fifo_top_defines.svh"

module ps2_mouse_packet_assembler_fifo_top #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ps2mpa_pkg::REQ_TDATA_W-1:0]  req_tdata,  // [7:0] data_byte
   input  logic [ps2mpa_pkg::REQ_TUSER_W-1:0]  req_tuser,  // [0] command, [1] from_aux
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ps2mpa_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // [2:0] buttons, [10:3] delta_x,
                                                           // [18:11] delta_y, [23:19] zero
   output logic [ps2mpa_pkg::RSP_TUSER_W-1:0]  rsp_tuser   // [0] read_ok
);
   import ps2mpa_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

   logic                 req_acc;
   logic                 is_read;
   logic                 is_aux_byte;
   logic                 s1_move;
   logic                 out_load;
   logic                 queue_empty;
   logic                 queue_full;
   logic                 push_en;
   logic                 pop_en;
   logic [PTR_W-1:0]     wr_next;
   logic [PTR_W-1:0]     rd_next;
   entry_type            push_entry;
   entry_type            out_entry_in;

   logic [1:0]           pos_ff, pos_in;
   logic [BUTTONS_W-1:0] first_ff, first_in;
   logic [BYTE_W-1:0]    second_ff, second_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_ok_ff, s1_ok_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_ok_ff;
   entry_type            out_entry_ff;
   entry_type            ram_rd_ff;

   entry_type            packet_mem [QUEUE_DEPTH];

   assign req_tready  = !(s1_valid_ff && out_valid_ff && !rsp_tready);
   assign req_acc     = req_tvalid && req_tready;
   assign is_read     = (req_tuser[0] == CMD_READ);
   assign is_aux_byte = (req_tuser[0] == CMD_DATA) && req_tuser[1];

   assign wr_next     = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_next     = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
   assign queue_empty = (rd_ptr_ff == wr_ptr_ff);
   assign queue_full  = (wr_next == rd_ptr_ff);

   assign push_en = req_acc && is_aux_byte && (pos_ff == POS_THIRD) && !queue_full;
   assign pop_en  = req_acc && is_read && !queue_empty;

   assign push_entry.buttons = first_ff;
   assign push_entry.delta_x = second_ff;
   assign push_entry.delta_y = req_tdata[BYTE_W-1:0];

   assign out_load = !out_valid_ff || rsp_tready;
   assign s1_move  = s1_valid_ff && out_load;

   always_comb begin
      pos_in    = pos_ff;
      first_in  = first_ff;
      second_in = second_ff;
      if (req_acc && is_aux_byte) begin
         unique case (pos_ff)
            POS_FIRST: begin
               if (req_tdata[SYNC_BIT]) begin
                  first_in = req_tdata[BUTTONS_W-1:0];
                  pos_in   = POS_SECOND;
               end
            end
            POS_SECOND: begin
               second_in = req_tdata[BYTE_W-1:0];
               pos_in    = POS_THIRD;
            end
            POS_THIRD: pos_in = POS_FIRST;
            default:   pos_in = POS_FIRST;
         endcase
      end
   end

   always_comb begin
      wr_ptr_in = push_en ? wr_next : wr_ptr_ff;
      rd_ptr_in = pop_en ? rd_next : rd_ptr_ff;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff && !out_load;
      s1_ok_in    = s1_ok_ff;
      if (req_acc && is_read) begin
         s1_valid_in = 1'b1;
         s1_ok_in    = !queue_empty;
      end
      out_valid_in = out_valid_ff && !rsp_tready;
      if (s1_move) begin
         out_valid_in = 1'b1;
      end
      out_entry_in = s1_ok_ff ? ram_rd_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         packet_mem[wr_ptr_ff] <= push_entry;
      end
      if (pop_en) begin
         ram_rd_ff <= packet_mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_FIRST;
         first_ff     <= '0;
         second_ff    <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ok_ff <= s1_ok_in;
      if (s1_move) begin
         out_ok_ff    <= s1_ok_ff;
         out_entry_ff <= out_entry_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ok_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - ENTRY_W)'(0), out_entry_ff};

   `PS2MPA_ASSERT(a_ptr_range, clock, reset, (rd_ptr_ff <= LAST_SLOT) && (wr_ptr_ff <= LAST_SLOT), "queue pointer out of range")
   `PS2MPA_ASSERT(a_push_not_full, clock, reset, push_en |-> (wr_next != rd_ptr_ff), "push into a full queue")
   `PS2MPA_ASSERT(a_read_lands, clock, reset, (req_acc && is_read) |=> s1_valid_ff, "read request lost before output stage")
   `PS2MPA_ASSERT(a_s1_hold, clock, reset, (s1_valid_ff && !out_load) |=> (s1_valid_ff && $stable(s1_ok_ff)), "stalled read stage changed")
   `PS2MPA_ASSERT_ALWAYS(a_rst_idle, clock, $past(reset) |-> (!rsp_tvalid && (pos_ff == POS_FIRST)), "state not cleared by reset")

endmodule

/* tb/ps2_mouse_packet_assembler_fifo_top_test.sv */
// Stream testbench for the PS/2 mouse packet assembler: random words, predicted reports, checks.
module ps2_mouse_packet_assembler_fifo_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ps2mpa_pkg::*;

   localparam int QUEUE_DEPTH    = 64;
   localparam int RANDOM_WORDS   = 1500;
   localparam int CALM_TAIL      = 200;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_AT        = 150;
   localparam int HOLD_CYCLES    = 500;

   typedef struct packed {
      logic             cmd;
      logic             aux;
      logic [BYTE_W-1:0] data;
   } word_type;

   typedef struct packed {
      logic      read_ok;
      entry_type pkt;
   } report_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   word_type   outgoing_words[$];
   report_type due_reports[$];
   word_type   offered;
   report_type want;
   entry_type  seen;

   logic [1:0]        pkt_pos = POS_FIRST;
   logic [BYTE_W-1:0] held_first = '0;
   logic [BYTE_W-1:0] held_second = '0;
   entry_type         packet_ring[QUEUE_DEPTH];
   int                rd_ptr = 0;
   int                wr_ptr = 0;

   int error_count = 0;
   int words_taken = 0;
   int reports_taken = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int quiet_cycles = 0;

   ps2_mouse_packet_assembler_fifo_top #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   function automatic bit calm();
      return outgoing_words.size() < CALM_TAIL;
   endfunction

   function automatic int ring_next(input int p);
      return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
   endfunction

   // assemble aux bytes into packets, pop on read
   function automatic void track_mouse_word(input word_type w);
      report_type r;
      r = '0;
      if (w.cmd == CMD_DATA) begin
         if (w.aux) begin
            case (pkt_pos)
               POS_FIRST: begin
                  if (w.data[SYNC_BIT]) begin
                     held_first = w.data;
                     pkt_pos = POS_SECOND;
                  end
               end
               POS_SECOND: begin
                  held_second = w.data;
                  pkt_pos = POS_THIRD;
               end
               default: begin
                  pkt_pos = POS_FIRST;
                  if (ring_next(wr_ptr) != rd_ptr) begin
                     packet_ring[wr_ptr].buttons = held_first[BUTTONS_W-1:0];
                     packet_ring[wr_ptr].delta_x = held_second;
                     packet_ring[wr_ptr].delta_y = w.data;
                     wr_ptr = ring_next(wr_ptr);
                  end
               end
            endcase
         end
      end else begin
         if (rd_ptr != wr_ptr) begin
            r.read_ok = 1'b1;
            r.pkt = packet_ring[rd_ptr];
            rd_ptr = ring_next(rd_ptr);
         end
         due_reports.push_back(r);
      end
   endfunction

   function automatic void check_field(input string name, input logic signed [31:0] exp_v,
                                       input logic signed [31:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endfunction

   task automatic push_word(input logic cmd, input logic [BYTE_W-1:0] data, input logic aux);
      word_type w;
      w.cmd = cmd;
      w.data = data;
      w.aux = aux;
      outgoing_words.push_back(w);
   endtask

   task automatic push_packet(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
                              input logic [BYTE_W-1:0] b2);
      push_word(CMD_DATA, b0, 1'b1);
      push_word(CMD_DATA, b1, 1'b1);
      push_word(CMD_DATA, b2, 1'b1);
   endtask

   initial begin
      forever #1 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_mouse_word(offered);
            words_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (outgoing_words.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (!calm() && words_taken[8] && $urandom_range(0, 11) == 0) begin
               req_gap = $urandom_range(0, 17);
               req_tvalid <= 1'b0;
            end else begin
               offered = outgoing_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= offered.data;
               req_tuser <= {offered.aux, offered.cmd};
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_reports.size() == 0) begin
               $display("%0t: unexpected report, expected none, actual tuser %h tdata %h",
                        $time, rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               want = due_reports.pop_front();
               seen = entry_type'(rsp_tdata[ENTRY_W-1:0]);
               check_field("read_ok", 32'(want.read_ok), 32'(rsp_tuser[0]));
               check_field("buttons", 32'(want.pkt.buttons), 32'(seen.buttons));
               check_field("delta_x", 32'(want.pkt.delta_x), 32'(seen.delta_x));
               check_field("delta_y", 32'(want.pkt.delta_y), 32'(seen.delta_y));
               check_field("tdata pad", 0, 32'(rsp_tdata[RSP_TDATA_W-1:ENTRY_W]));
            end
            reports_taken++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && !calm() && reports_taken >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (!calm() && reports_taken[6] && $urandom_range(0, 9) == 0) begin
            rsp_gap = $urandom_range(0, 17);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      int kind;
      int floods;
      logic [BYTE_W-1:0] b0;
      floods = 0;

      push_word(CMD_READ, 8'hFF, 1'b1);
      push_word(CMD_DATA, 8'h08, 1'b0);
      push_word(CMD_DATA, 8'h00, 1'b1);
      push_word(CMD_DATA, 8'hF7, 1'b1);
      push_packet(8'hFF, 8'h80, 8'h7F);
      push_word(CMD_READ, 8'h00, 1'b0);
      push_word(CMD_DATA, 8'h08, 1'b1);
      push_word(CMD_DATA, 8'hFF, 1'b0);
      push_word(CMD_DATA, 8'h7F, 1'b1);
      push_word(CMD_DATA, 8'h80, 1'b1);
      push_word(CMD_DATA, 8'h0F, 1'b1);
      push_word(CMD_READ, 8'hA5, 1'b1);
      push_word(CMD_DATA, 8'h00, 1'b1);
      push_word(CMD_DATA, 8'hFF, 1'b1);
      push_word(CMD_READ, 8'h5A, 1'b0);
      push_word(CMD_READ, 8'hFF, 1'b1);
      push_word(CMD_READ, 8'h00, 1'b0);

      while (outgoing_words.size() < RANDOM_WORDS) begin
         if (floods < 2 && outgoing_words.size() > 500 * (floods + 1)) begin
            // overfill the ring, then drain past empty
            for (int i = 0; i < 70; i++) begin
               b0 = 8'($urandom);
               b0[SYNC_BIT] = 1'b1;
               push_packet(b0, 8'($urandom), 8'($urandom));
            end
            for (int i = 0; i < 80; i++) begin
               push_word(CMD_READ, 8'($urandom), 1'($urandom));
            end
            floods++;
         end
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2, 3, 4, 5: begin
               b0 = 8'($urandom);
               b0[SYNC_BIT] = 1'b1;
               push_word(CMD_DATA, b0, 1'b1);
               if ($urandom_range(0, 7) == 0) push_word(CMD_DATA, 8'($urandom), 1'b0);
               push_word(CMD_DATA, 8'($urandom), 1'b1);
               if ($urandom_range(0, 7) == 0) push_word(CMD_READ, 8'($urandom), 1'($urandom));
               push_word(CMD_DATA, 8'($urandom), 1'b1);
            end
            6, 7: begin
               repeat ($urandom_range(1, 4)) push_word(CMD_READ, 8'($urandom), 1'($urandom));
            end
            8: begin
               push_word(CMD_DATA, 8'($urandom), 1'($urandom));
            end
            default: begin
               // truncated packet: knocks the following bytes out of line
               b0 = 8'($urandom);
               b0[SYNC_BIT] = $urandom_range(0, 3) == 0;
               push_word(CMD_DATA, b0, 1'b1);
               if ($urandom_range(0, 1)) push_word(CMD_DATA, 8'($urandom), 1'b1);
            end
         endcase
      end
      repeat (64) push_word(CMD_READ, 8'($urandom), 1'($urandom));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (outgoing_words.size() != 0 || req_tvalid || due_reports.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
